// File: hdl/cau_pkg.sv
// Shared constants and types of the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned EXP_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POW = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_FIN  = 6'b000100,
    S_DIV  = 6'b001000,
    S_DFIN = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

// File: hdl/cau_if.sv
// Valid/ready channel interfaces for the operand and result transfers.
interface cau_in_if #(
  parameter int unsigned DW = 16
);
  logic                               valid;
  logic                               ready;
  logic        [cau_pkg::CMD_W-1:0]   command;
  logic signed [DW-1:0]               a_re;
  logic signed [DW-1:0]               a_im;
  logic signed [DW-1:0]               b_re;
  logic signed [DW-1:0]               b_im;
  logic signed [cau_pkg::EXP_W-1:0]   exponent;

  modport source (output valid, command, a_re, a_im, b_re, b_im, exponent, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, exponent, output ready);
endinterface

interface cau_out_if #(
  parameter int unsigned DW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_re;
  logic signed [DW-1:0] res_im;
  logic                 overflow;
  logic                 div_by_zero;

  modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface

// File: hdl/complex_arithmetic_unit.sv
// Complex-number ALU on signed fixed point with a shared multiplier and a serial divider.
//
// The block takes one command with two complex operands on in_i and returns one
// result on out_o; both channels transfer when valid and ready are high at a
// rising clock edge. in_i.ready is high only while the sequencer is idle, so one
// item is worked on at a time.
// Steps from the input transfer to out_o.valid, with no stall on the output:
//   add, subtract, undefined commands: the result is registered, then moved to the output register.
//   multiply: the partial products pass through the single signed multiplier, then
//   the scaling and saturation state runs, then the output register is loaded.
//   power: an exponent of zero or below goes straight to the output register; else
//   every step runs the complex multiply again through the same multiplier.
//   divide: after the products, the restoring divider retires one quotient bit
//   per cycle for the real part and then for the imaginary part, NW quotient bits
//   each, NW = 2*DATA_WIDTH+1+FRAC_BITS. A zero divisor ends after the products.
// A finished result sits in the output register; the next item is accepted as
// soon as the sequencer is idle again, even while that result waits. If the
// receiver stalls and a second result is finished, the sequencer holds it until
// the output register is free.
// Reset clears the sequencer and the output valid flag; no result is pending.
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cau_in_if.sink   in_i,
  cau_out_if.source out_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned PW    = 2 * DW;          // product width
  localparam int unsigned ACC_W = PW + 1;          // sum of two products
  localparam int unsigned RW    = PW;              // divisor and remainder width
  localparam int unsigned NW    = ACC_W + FRAC_BITS; // dividend magnitude width
  localparam int unsigned SW    = NW + 1;          // common signed width before saturation
  localparam int unsigned CW    = $clog2(NW + 1);

  localparam logic signed [SW-1:0] MAXV = SW'((64'(1) << (DW - 1)) - 64'(1));
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
  localparam logic signed [SW-1:0] ONEV = SW'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]     BIAS = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);

  function automatic logic [DW-1:0] sat_f(input logic signed [SW-1:0] v);
    if (v > MAXV) begin
      return MAXV[DW-1:0];
    end else if (v < MINV) begin
      return MINV[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic logic ovf_f(input logic signed [SW-1:0] v);
    return (v > MAXV) || (v < MINV);
  endfunction

  // Truncating scale by 2^FRAC_BITS toward zero, widened for saturation.
  function automatic logic signed [SW-1:0] scale_f(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = $signed(v + (v[ACC_W-1] ? BIAS : '0)) >>> FRAC_BITS;
    return {{(SW - ACC_W){s[ACC_W-1]}}, s};
  endfunction

  cau_pkg::state_e state_q, state_d;

  logic [cau_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic signed [DW-1:0]      xr_q, xr_d, xi_q, xi_d, yr_q, yr_d, yi_q, yi_d;
  logic [2:0]                ph_q, ph_d;
  logic [cau_pkg::EXP_W-2:0] pcnt_q, pcnt_d;
  logic signed [PW-1:0]      prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [RW-1:0]             m_q, m_d;
  logic [RW-1:0]             rem_q, rem_d;
  logic [NW-1:0]             dq_q, dq_d;
  logic [CW-1:0]             dcnt_q, dcnt_d;
  logic                      dneg_q, dneg_d, dsel_q, dsel_d;
  logic                      ovf_q, ovf_d, dz_q, dz_d;

  logic                      ov_q, ov_d;
  logic signed [DW-1:0]      ore_q, ore_d, oim_q, oim_d;
  logic                      oovf_q, oovf_d, odz_q, odz_d;

  logic signed [DW-1:0]      mop_a, mop_b;
  logic [2:0]                ph_j, ph_last;
  logic                      is_div, acc_sub;
  logic signed [ACC_W-1:0]   prod_ext, acc_add;
  logic signed [SW-1:0]      sum_re, sum_im, sc_re, sc_im, q_s;
  logic [RW:0]               div_t;
  logic                      div_ge;

  assign in_i.ready        = (state_q == cau_pkg::S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.res_re      = ore_q;
  assign out_o.res_im      = oim_q;
  assign out_o.overflow    = oovf_q;
  assign out_o.div_by_zero = odz_q;

  assign is_div  = (cmd_q == cau_pkg::CMD_DIV);
  assign ph_last = is_div ? 3'd6 : 3'd4;
  assign ph_j    = ph_q - 3'd1;

  // One signed multiplier, fed in turn with the partial products.
  always_comb begin
    unique case (ph_q)
      3'd0:    begin mop_a = xr_q; mop_b = yr_q; end
      3'd1:    begin mop_a = xi_q; mop_b = yi_q; end
      3'd2:    begin mop_a = xr_q; mop_b = yi_q; end
      3'd3:    begin mop_a = xi_q; mop_b = yr_q; end
      3'd4:    begin mop_a = yr_q; mop_b = yr_q; end
      3'd5:    begin mop_a = yi_q; mop_b = yi_q; end
      default: begin mop_a = '0;   mop_b = '0;   end
    endcase
  end

  assign prod_ext = {prod_q[PW-1], prod_q};
  assign acc_sub  = is_div ? (ph_j == 3'd2) : (ph_j == 3'd1);
  assign acc_add  = acc_sub ? -prod_ext : prod_ext;

  assign sum_re = cmd_d == cau_pkg::CMD_SUB
                  ? SW'(in_i.a_re) - SW'(in_i.b_re) : SW'(in_i.a_re) + SW'(in_i.b_re);
  assign sum_im = cmd_d == cau_pkg::CMD_SUB
                  ? SW'(in_i.a_im) - SW'(in_i.b_im) : SW'(in_i.a_im) + SW'(in_i.b_im);
  assign sc_re  = scale_f(acc_re_q);
  assign sc_im  = scale_f(acc_im_q);

  assign div_t  = {rem_q, dq_q[NW-1]};
  assign div_ge = div_t >= {1'b0, m_q};
  assign q_s    = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    xr_d     = xr_q;
    xi_d     = xi_q;
    yr_d     = yr_q;
    yi_d     = yi_q;
    ph_d     = ph_q;
    pcnt_d   = pcnt_q;
    prod_d   = mop_a * mop_b;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    m_d      = m_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    dcnt_d   = dcnt_q;
    dneg_d   = dneg_q;
    dsel_d   = dsel_q;
    ovf_d    = ovf_q;
    dz_d     = dz_q;
    ov_d     = ov_q && !out_o.ready;
    ore_d    = ore_q;
    oim_d    = oim_q;
    oovf_d   = oovf_q;
    odz_d    = odz_q;

    unique case (state_q)
      cau_pkg::S_IDLE: begin
        cmd_d = in_i.command;
        if (in_i.valid) begin
          ph_d     = '0;
          acc_re_d = '0;
          acc_im_d = '0;
          m_d      = '0;
          dsel_d   = 1'b0;
          dz_d     = 1'b0;
          ovf_d    = 1'b0;
          xr_d     = '0;
          xi_d     = '0;
          yr_d     = in_i.b_re;
          yi_d     = in_i.b_im;
          state_d  = cau_pkg::S_DONE;
          priority if (cmd_d == cau_pkg::CMD_ADD || cmd_d == cau_pkg::CMD_SUB) begin
            xr_d  = sat_f(sum_re);
            xi_d  = sat_f(sum_im);
            ovf_d = ovf_f(sum_re) || ovf_f(sum_im);
          end else if (cmd_d == cau_pkg::CMD_MUL || cmd_d == cau_pkg::CMD_DIV) begin
            xr_d    = in_i.a_re;
            xi_d    = in_i.a_im;
            state_d = cau_pkg::S_MUL;
          end else if (cmd_d == cau_pkg::CMD_POW) begin
            xr_d   = sat_f(ONEV);
            ovf_d  = ovf_f(ONEV);
            yr_d   = in_i.a_re;
            yi_d   = in_i.a_im;
            pcnt_d = in_i.exponent[cau_pkg::EXP_W-2:0];
            if (!in_i.exponent[cau_pkg::EXP_W-1] && (in_i.exponent != '0)) begin
              state_d = cau_pkg::S_MUL;
            end
          end else begin
            xr_d = '0;
          end
        end
      end

      cau_pkg::S_MUL: begin
        ph_d = ph_q + 3'd1;
        if (ph_q != 3'd0) begin
          if (ph_j < 3'd2) begin
            acc_re_d = acc_re_q + acc_add;
          end else if (ph_j < 3'd4) begin
            acc_im_d = acc_im_q + acc_add;
          end else begin
            m_d = m_q + RW'(prod_q);
          end
        end
        if (ph_q == ph_last) begin
          ph_d = '0;
          if (!is_div) begin
            state_d = cau_pkg::S_FIN;
          end else if (m_d == '0) begin
            dz_d    = 1'b1;
            xr_d    = '0;
            xi_d    = '0;
            state_d = cau_pkg::S_DONE;
          end else begin
            state_d = cau_pkg::S_DIV;
            dneg_d  = acc_re_d[ACC_W-1];
            dq_d    = NW'(acc_re_d[ACC_W-1] ? -acc_re_d : acc_re_d) << FRAC_BITS;
            rem_d   = '0;
            dcnt_d  = CW'(NW);
          end
        end
      end

      cau_pkg::S_FIN: begin
        xr_d     = sat_f(sc_re);
        xi_d     = sat_f(sc_im);
        ovf_d    = ovf_q || ovf_f(sc_re) || ovf_f(sc_im);
        acc_re_d = '0;
        acc_im_d = '0;
        pcnt_d   = pcnt_q - 1'b1;
        if (cmd_q == cau_pkg::CMD_POW && pcnt_q != (cau_pkg::EXP_W-1)'(1)) begin
          state_d = cau_pkg::S_MUL;
        end else begin
          state_d = cau_pkg::S_DONE;
        end
      end

      cau_pkg::S_DIV: begin
        rem_d  = div_ge ? RW'(div_t - {1'b0, m_q}) : RW'(div_t);
        dq_d   = {dq_q[NW-2:0], div_ge};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == CW'(1)) begin
          state_d = cau_pkg::S_DFIN;
        end
      end

      cau_pkg::S_DFIN: begin
        ovf_d = ovf_q || ovf_f(q_s);
        if (!dsel_q) begin
          xr_d    = sat_f(q_s);
          dsel_d  = 1'b1;
          dneg_d  = acc_im_q[ACC_W-1];
          dq_d    = NW'(acc_im_q[ACC_W-1] ? -acc_im_q : acc_im_q) << FRAC_BITS;
          rem_d   = '0;
          dcnt_d  = CW'(NW);
          state_d = cau_pkg::S_DIV;
        end else begin
          xi_d    = sat_f(q_s);
          state_d = cau_pkg::S_DONE;
        end
      end

      cau_pkg::S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          ore_d   = xr_q;
          oim_d   = xi_q;
          oovf_d  = ovf_q;
          odz_d   = dz_q;
          state_d = cau_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cau_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cau_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    xr_q     <= xr_d;
    xi_q     <= xi_d;
    yr_q     <= yr_d;
    yi_q     <= yi_d;
    ph_q     <= ph_d;
    pcnt_q   <= pcnt_d;
    prod_q   <= prod_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    m_q      <= m_d;
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    dcnt_q   <= dcnt_d;
    dneg_q   <= dneg_d;
    dsel_q   <= dsel_d;
    ovf_q    <= ovf_d;
    dz_q     <= dz_d;
    ore_q    <= ore_d;
    oim_q    <= oim_d;
    oovf_q   <= oovf_d;
    odz_q    <= odz_d;
  end

endmodule

// File: hdl/cau_checker.sv
// Port-level assertions for the complex arithmetic unit and their binding.
module cau_checker #(
  parameter int unsigned DW = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [DW-1:0] res_re_i,
  input logic [DW-1:0] res_im_i,
  input logic          overflow_i,
  input logic          div_by_zero_i
);

  // The sequencer is busy in the cycle after it takes an item.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_re_i) && $stable(res_im_i)
      && $stable(overflow_i) && $stable(div_by_zero_i))
    else $error("stalled result changed");

  // A zero divisor gives a zero result with no overflow.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && div_by_zero_i |-> !overflow_i && res_re_i == '0 && res_im_i == '0)
    else $error("divide by zero result not clean");

endmodule

bind complex_arithmetic_unit cau_checker #(.DW(DATA_WIDTH)) u_cau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .res_re_i      (out_o.res_re),
  .res_im_i      (out_o.res_im),
  .overflow_i    (out_o.overflow),
  .div_by_zero_i (out_o.div_by_zero)
);
